FILE: rtl/tlf_pkg.sv
// ============================================================================
// tlf_pkg: shared types and constants of the text line folder
// Character codes, controller states, command and status bundles.
// ============================================================================
`default_nettype none

package tlf_pkg;

    localparam int CHAR_W = 8;
    localparam int CFG_W  = 6;

    localparam logic [CFG_W-1:0]  WIDTH_RESET = 6'd5;
    localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
    localparam logic [CHAR_W-1:0] CH_HYPHEN   = 8'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_EMIT,
        ST_HYPH,
        ST_NL,
        ST_MOVE_PREP,
        ST_MOVE,
        ST_APPEND
    } state_t;

    // What the accepted item asks for.
    typedef enum logic [2:0] {
        K_FLUSH,
        K_NEWLINE,
        K_FOLD_BLANK,
        K_FOLD_HYPHEN,
        K_APPEND
    } kind_t;

    typedef enum logic [1:0] {
        OSEL_STORE,
        OSEL_HYPHEN,
        OSEL_NEWLINE
    } out_sel_t;

    typedef struct packed {
        logic     accept;
        logic     idx_clr;
        logic     idx_inc;
        logic     rd_move;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
        logic     move_wr;
        logic     line_clear;
        logic     move_finish;
        logic     append;
    } tlf_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  emit_done;
        logic  emit_last;
        logic  move_done;
        logic  out_free;
    } tlf_status_t;

endpackage

`default_nettype wire

FILE: rtl/tlf_in_if.sv
// ============================================================================
// tlf_in_if: input character channel
// One character or an end-of-input mark per transfer.
// ============================================================================
`default_nettype none

interface tlf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_input;

    modport source (output valid, output in_char, output end_of_input, input ready);
    modport sink   (input valid, input in_char, input end_of_input, output ready);
endinterface

`default_nettype wire

FILE: rtl/tlf_out_if.sv
// ============================================================================
// tlf_out_if: output character channel
// One emitted byte per transfer, with a mark on the last byte of a run.
// ============================================================================
`default_nettype none

interface tlf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/tlf_cfg_if.sv
// ============================================================================
// tlf_cfg_if: configuration write channel
// Carries the line width register value.
// ============================================================================
`default_nettype none

interface tlf_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] line_width;

    modport source (output valid, output line_width, input ready);
    modport sink   (input valid, input line_width, output ready);
endinterface

`default_nettype wire

FILE: rtl/text_line_folder_top.sv
// ============================================================================
// text_line_folder_top: folds a character stream into lines of bounded width
// Breaks at the latest blank, or hyphenates a line that has no blank.
// ============================================================================
//
//   Channel  Direction  Payload                     Transfer when
//   in_ch    in         in_char, end_of_input       valid && ready
//   out_ch   out        out_char, last_of_run       valid && ready
//   cfg      in         line_width                  valid && ready (ready tied high)
//
// Reset leaves an empty line and a line width of 5; no clearing pass is needed.
// A stalled output holds the sequencer; no new item is taken until the current
// one has handed all its bytes to the output register.
// ============================================================================
`default_nettype none

module text_line_folder_top #(
    parameter int MAX_WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tlf_in_if.sink     in_ch,
    tlf_out_if.source  out_ch,
    tlf_cfg_if.sink    cfg
);

    import tlf_pkg::*;

    tlf_cmd_t    cmd;
    tlf_status_t status;

    assign cfg.ready = 1'b1;

    tlf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    tlf_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_char        (in_ch.in_char),
        .end_of_input   (in_ch.end_of_input),
        .cfg_valid      (cfg.valid),
        .cfg_line_width (cfg.line_width),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (out_ch.ready),
        .out_valid      (out_ch.valid),
        .out_char       (out_ch.out_char),
        .last_of_run    (out_ch.last_of_run)
    );

endmodule

`default_nettype wire

FILE: rtl/tlf_ram.sv
// ============================================================================
// tlf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module tlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/tlf_ctrl.sv
// ============================================================================
// tlf_ctrl: sequencing controller of the text line folder
// Steps one item through emission, inserted bytes, line move and append.
// ============================================================================
`default_nettype none

module tlf_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire tlf_pkg::tlf_status_t status,
    output tlf_pkg::tlf_cmd_t         cmd
);

    import tlf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.out_sel = OSEL_STORE;
        in_ready   = 1'b0;
        state_next = state_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept  = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_PREP;
                end
            end

            // The store read of column zero is issued here.
            ST_PREP:
            begin
                if (status.kind == K_APPEND)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (status.emit_done)
                begin
                    case (status.kind)
                        K_FLUSH:
                        begin
                            cmd.line_clear = 1'b1;
                            state_next     = ST_IDLE;
                        end
                        K_FOLD_HYPHEN: state_next = ST_HYPH;
                        default:       state_next = ST_NL;
                    endcase
                end
                else if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OSEL_STORE;
                    cmd.out_last = status.emit_last && (status.kind == K_FLUSH);
                    cmd.idx_inc  = 1'b1;
                end
            end

            ST_HYPH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OSEL_HYPHEN;
                    state_next   = ST_NL;
                end
            end

            ST_NL:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OSEL_NEWLINE;
                    cmd.out_last = 1'b1;
                    case (status.kind)
                        K_FOLD_BLANK:
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = ST_MOVE_PREP;
                        end
                        K_FOLD_HYPHEN:
                        begin
                            cmd.line_clear = 1'b1;
                            state_next     = ST_APPEND;
                        end
                        default:
                        begin
                            cmd.line_clear = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_MOVE_PREP:
            begin
                cmd.rd_move = 1'b1;
                state_next  = ST_MOVE;
            end

            // Text after the blank shifts to the front, one byte per cycle.
            ST_MOVE:
            begin
                cmd.rd_move = 1'b1;
                if (status.move_done)
                begin
                    cmd.move_finish = 1'b1;
                    state_next      = ST_APPEND;
                end
                else
                begin
                    cmd.move_wr = 1'b1;
                    cmd.idx_inc = 1'b1;
                end
            end

            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/tlf_dp.sv
// ============================================================================
// tlf_dp: datapath of the text line folder
// Line store, fill and blank tracking, width register and output register.
// ============================================================================
`default_nettype none

module tlf_dp #(
    parameter int MAX_WIDTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [tlf_pkg::CHAR_W-1:0]  in_char,
    input  wire logic                        end_of_input,
    input  wire logic                        cfg_valid,
    input  wire logic [tlf_pkg::CFG_W-1:0]   cfg_line_width,
    input  wire tlf_pkg::tlf_cmd_t           cmd,
    output tlf_pkg::tlf_status_t             status,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic      [tlf_pkg::CHAR_W-1:0]  out_char,
    output logic                             last_of_run
);

    import tlf_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);

    logic [CFG_W-1:0]  width_reg;
    logic [CW-1:0]     fill_reg;
    logic [CW-1:0]     fill_next;
    logic [AW-1:0]     bp_reg;
    logic [AW-1:0]     bp_next;
    logic              seen_reg;
    logic              seen_next;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     idx_next;
    kind_t             kind_reg;
    kind_t             kind_next;
    logic [CHAR_W-1:0] char_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CHAR_W-1:0] out_char_reg;
    logic [CHAR_W-1:0] out_char_next;
    logic              out_last_reg;

    logic [CFG_W-1:0]  eff_width;
    logic              line_full;
    logic              blank_usable;
    logic [CW-1:0]     emit_len;
    logic [CW-1:0]     rest_len;
    logic [CW:0]       rd_base;
    logic [CW:0]       rd_off;
    logic [CW:0]       rd_sum;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;
    logic              char_blank;

    // Width zero acts as one; widths past the store depth act as the depth.
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_width = CFG_W'(1);
        end
        else if (width_reg > CFG_W'(MAX_WIDTH))
        begin
            eff_width = CFG_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_reg;
        end
    end

    assign line_full    = CFG_W'(fill_reg) >= eff_width;
    assign blank_usable = seen_reg && (CW'(bp_reg) < fill_reg);
    assign char_blank   = (char_reg == CH_SPACE) || (char_reg == CH_TAB);

    always_comb
    begin
        if (end_of_input)
        begin
            kind_next = K_FLUSH;
        end
        else if (in_char == CH_NEWLINE)
        begin
            kind_next = K_NEWLINE;
        end
        else if (line_full)
        begin
            kind_next = blank_usable ? K_FOLD_BLANK : K_FOLD_HYPHEN;
        end
        else
        begin
            kind_next = K_APPEND;
        end
    end

    assign emit_len = (kind_reg == K_FOLD_BLANK) ? CW'(bp_reg) : fill_reg;
    assign rest_len = fill_reg - CW'(bp_reg) - CW'(1);

    assign status.kind      = kind_reg;
    assign status.emit_done = idx_reg == emit_len;
    assign status.emit_last = ((CW + 1)'(idx_reg) + (CW + 1)'(1)) == (CW + 1)'(emit_len);
    assign status.move_done = idx_reg == rest_len;
    assign status.out_free  = !out_valid_reg || out_ready;

    // The read address runs one ahead when the index advances, so the
    // registered read data belongs to the current index whenever bytes are emitted or moved.
    assign rd_base   = cmd.rd_move ? ((CW + 1)'(bp_reg) + (CW + 1)'(1)) : '0;
    assign rd_off    = (CW + 1)'(idx_reg) + (CW + 1)'(cmd.idx_inc);
    assign rd_sum    = rd_base + rd_off;
    assign ram_raddr = rd_sum[AW-1:0];

    assign ram_we    = cmd.move_wr || cmd.append;
    assign ram_waddr = cmd.move_wr ? idx_reg[AW-1:0] : fill_reg[AW-1:0];
    assign ram_wdata = cmd.move_wr ? ram_rdata : char_reg;

    tlf_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        fill_next = fill_reg;
        bp_next   = bp_reg;
        seen_next = seen_reg;
        if (cmd.line_clear)
        begin
            fill_next = '0;
            bp_next   = '0;
            seen_next = 1'b0;
        end
        else if (cmd.move_finish)
        begin
            fill_next = rest_len;
            bp_next   = '0;
            seen_next = 1'b0;
        end
        else if (cmd.append)
        begin
            fill_next = fill_reg + CW'(1);
            if (char_blank)
            begin
                bp_next   = fill_reg[AW-1:0];
                seen_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_comb
    begin
        case (cmd.out_sel)
            OSEL_HYPHEN:  out_char_next = CH_HYPHEN;
            OSEL_NEWLINE: out_char_next = CH_NEWLINE;
            default:      out_char_next = ram_rdata;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            fill_reg      <= '0;
            bp_reg        <= '0;
            seen_reg      <= 1'b0;
            idx_reg       <= '0;
            kind_reg      <= K_APPEND;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                width_reg <= cfg_line_width;
            end
            if (cmd.accept)
            begin
                kind_reg <= kind_next;
            end
            fill_reg      <= fill_next;
            bp_reg        <= bp_next;
            seen_reg      <= seen_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            char_reg <= in_char;
        end
        if (cmd.out_load)
        begin
            out_char_reg <= out_char_next;
            out_last_reg <= cmd.out_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign last_of_run = out_last_reg;

endmodule

`default_nettype wire
